[rtl/owrf_pkg.sv]
// ----------------------------------------------------------------------------
// owrf_pkg: shared definitions for the overwriting ring FIFO
// Default sizes and operation codes used by the ring FIFO.
// ----------------------------------------------------------------------------
package owrf_pkg;

  localparam int unsigned DEF_SLOTS       = 16;
  localparam int unsigned DEF_RECORD_BITS = 64;

  // Fixed widths of the request and result fields.
  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned COUNT_W  = 4;

  // Operation codes carried in func.
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

endpackage

[rtl/overwrite_oldest_ring_fifo.sv]
// ----------------------------------------------------------------------------
// overwrite_oldest_ring_fifo: ring FIFO that drops its oldest record when full
// Pipeline: each result is registered in the first stage and then in the
// result register, and is held there while the result side stalls.
// Throughput: one push or pop per cycle unless the result side stalls, limited
// by the single memory port pair (one write, one registered read) per request.
// Reset: both pointers return to zero (empty); record storage is not cleared.
// ----------------------------------------------------------------------------
module overwrite_oldest_ring_fifo
  import owrf_pkg::*;
#(
  parameter int unsigned SLOTS       = DEF_SLOTS,
  parameter int unsigned RECORD_BITS = DEF_RECORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [FUNC_W-1:0]      func,
  input  logic [WORD_W-1:0]      push_record,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   pop_ok,
  output logic [WORD_W-1:0]      pop_record,
  output logic                   dropped_oldest,
  output logic [COUNT_W-1:0]     unread_count
);

  localparam int unsigned PW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CEW = (PW > COUNT_W) ? PW : COUNT_W;

  localparam logic [PW-1:0] LAST_SLOT = PW'(SLOTS - 1);

  logic [RECORD_BITS-1:0] record_store [SLOTS];

  logic [PW-1:0] write_pointer, write_pointer_next;
  logic [PW-1:0] read_pointer, read_pointer_next;

  logic                   s1_valid, s1_valid_next;
  logic                   s1_ok, s1_dropped;
  logic [PW-1:0]          s1_count;
  logic [RECORD_BITS-1:0] s1_rdata;

  logic accept, is_push, is_pop, s2_load, s1_move;
  logic [PW-1:0] wp_inc, rp_inc;
  logic [PW-1:0] count_next;
  logic [PW:0]   count_wide;
  logic ok_next, dropped_next;
  logic [CEW-1:0]    count_ext;
  logic [WORD_W-1:0] rec_ext;

  assign s2_load    = !result_valid || !result_stall;
  assign s1_move    = s1_valid && s2_load;
  assign item_stall = s1_valid && !s2_load;
  assign accept     = item_valid && !item_stall;
  assign is_push    = (func == FUNC_PUSH);
  assign is_pop     = (func == FUNC_POP);

  assign wp_inc = (write_pointer == LAST_SLOT) ? '0 : write_pointer + PW'(1);
  assign rp_inc = (read_pointer == LAST_SLOT) ? '0 : read_pointer + PW'(1);

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    ok_next            = 1'b0;
    dropped_next       = 1'b0;
    if (accept) begin
      if (is_push) begin
        write_pointer_next = wp_inc;
        // The ring is full when the advanced head meets the tail.
        if (wp_inc == read_pointer) begin
          read_pointer_next = rp_inc;
          dropped_next      = 1'b1;
        end
      end else if (is_pop && (write_pointer != read_pointer)) begin
        read_pointer_next = rp_inc;
        ok_next           = 1'b1;
      end
    end
    if (write_pointer_next >= read_pointer_next) begin
      count_wide = {1'b0, write_pointer_next} - {1'b0, read_pointer_next};
    end else begin
      count_wide = {1'b0, write_pointer_next} - {1'b0, read_pointer_next}
                   + (PW+1)'(SLOTS);
    end
    count_next = count_wide[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_push) begin
      record_store[write_pointer] <= push_record[RECORD_BITS-1:0];
    end
  end

  // The read data holds while the first stage is stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rdata <= record_store[read_pointer];
    end
  end

  assign s1_valid_next = accept || (s1_valid && !s1_move);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok      <= ok_next;
      s1_dropped <= dropped_next;
      s1_count   <= count_next;
    end
  end

  always_comb begin
    count_ext           = '0;
    count_ext[PW-1:0]   = s1_count;
    rec_ext             = '0;
    if (s1_ok) begin
      rec_ext[RECORD_BITS-1:0] = s1_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pop_ok         <= s1_ok;
      pop_record     <= rec_ext;
      dropped_oldest <= s1_dropped;
      unread_count   <= count_ext[COUNT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // Both pointers stay inside the ring.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (write_pointer <= LAST_SLOT) && (read_pointer <= LAST_SLOT))
    else $error("ring pointer out of range");

  // After a push the ring can never be empty.
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push) |=> (write_pointer != read_pointer))
    else $error("ring empty after push");

  // A pop on an empty ring leaves both pointers alone.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && is_pop && (write_pointer == read_pointer))
      |=> ($stable(write_pointer) && $stable(read_pointer)))
    else $error("pointers moved on empty pop");

  // A result never reports both a popped record and a dropped record.
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(pop_ok && dropped_oldest))
    else $error("pop and drop in one result");
`endif

endmodule

[dv/overwrite_oldest_ring_fifo_tb.sv]
// ----------------------------------------------------------------------------
// overwrite_oldest_ring_fifo_tb: self-checking bench for the overwriting ring FIFO
// Pushes and pops are sent through the request channel while a shadow ring
// predicts each result. Every result is compared field by field, in order.
// The bench covers empty pops, extreme record words, overwrite when full,
// and long random push/pop mixes. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module overwrite_oldest_ring_fifo_tb;
  import owrf_pkg::*;

  localparam int unsigned RING_SLOTS = DEF_SLOTS;
  localparam logic [WORD_W-1:0] RECORD_MASK = {WORD_W{1'b1}} >> (WORD_W - DEF_RECORD_BITS);
  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

  typedef struct packed {
    logic               ok;
    logic [WORD_W-1:0]  rec;
    logic               dropped;
    logic [COUNT_W-1:0] count;
  } fifo_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [FUNC_W-1:0]   func = FUNC_PUSH;
  logic [WORD_W-1:0]   push_record = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic                pop_ok;
  logic [WORD_W-1:0]   pop_record;
  logic                dropped_oldest;
  logic [COUNT_W-1:0]  unread_count;

  // Shadow copy of the ring and its pointers.
  logic [WORD_W-1:0]   shadow_ring [RING_SLOTS];
  int unsigned         shadow_wr = 0;
  int unsigned         shadow_rd = 0;
  fifo_result_t        pending_results[$];

  bit                  request_gaps_on = 1'b1;
  bit                  result_stalls_on = 1'b1;
  int unsigned         stall_left = 0;
  int unsigned         errors = 0;
  int unsigned         n_requests = 0;
  int unsigned         n_results = 0;
  int unsigned         n_pops = 0;
  int unsigned         n_empty_pops = 0;
  int unsigned         n_drops = 0;

  overwrite_oldest_ring_fifo dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .func           (func),
    .push_record    (push_record),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .pop_ok         (pop_ok),
    .pop_record     (pop_record),
    .dropped_oldest (dropped_oldest),
    .unread_count   (unread_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic fifo_result_t predict_ring_result(input logic [FUNC_W-1:0] f,
                                                       input logic [WORD_W-1:0] rec);
    fifo_result_t res;
    int unsigned  next_wr;
    res = '0;
    if (f == FUNC_PUSH) begin
      next_wr = (shadow_wr + 1) % RING_SLOTS;
      shadow_ring[shadow_wr] = rec & RECORD_MASK;
      if (next_wr == shadow_rd) begin
        shadow_rd = (shadow_rd + 1) % RING_SLOTS;
        res.dropped = 1'b1;
      end
      shadow_wr = next_wr;
    end else if (shadow_wr != shadow_rd) begin
      res.ok  = 1'b1;
      res.rec = shadow_ring[shadow_rd] & RECORD_MASK;
      shadow_rd = (shadow_rd + 1) % RING_SLOTS;
    end
    res.count = COUNT_W'((shadow_wr + RING_SLOTS - shadow_rd) % RING_SLOTS);
    return res;
  endfunction

  // Result-side backpressure in random bursts.
  always @(posedge clk) begin
    if (rst || !result_stalls_on) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 15);
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic note_mismatch(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    errors++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    fifo_result_t got;
    fifo_result_t want;
    if (!rst && result_valid && !result_stall) begin
      got = '{pop_ok, pop_record, dropped_oldest, unread_count};
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding: expected none, actual %h",
                 $time, got);
      end else begin
        want = pending_results.pop_front();
        if (want.ok !== got.ok)
          note_mismatch("pop_ok", WORD_W'(want.ok), WORD_W'(got.ok));
        if (want.rec !== got.rec) note_mismatch("pop_record", want.rec, got.rec);
        if (want.dropped !== got.dropped)
          note_mismatch("dropped_oldest", WORD_W'(want.dropped), WORD_W'(got.dropped));
        if (want.count !== got.count)
          note_mismatch("unread_count", WORD_W'(want.count), WORD_W'(got.count));
      end
    end
  end

  // Drives one request and returns right after the edge that accepted it,
  // leaving item_valid high for the caller to reuse or lower.
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] rec);
    fifo_result_t res;
    if (request_gaps_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    func        <= f;
    push_record <= rec;
    item_valid  <= 1'b1;
    do @(posedge clk); while (item_stall);
    res = predict_ring_result(f, rec);
    pending_results.push_back(res);
    n_requests++;
    if (f == FUNC_POP) begin
      n_pops++;
      if (!res.ok) n_empty_pops++;
    end else if (res.dropped) begin
      n_drops++;
    end
  endtask

  task automatic wait_until_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] random_record();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_empty_pop();
    repeat (3) send_request(FUNC_POP, random_record());
  endtask

  task automatic test_extreme_records();
    send_request(FUNC_PUSH, '0);
    send_request(FUNC_PUSH, ALL_ONES);
    send_request(FUNC_POP, ALL_ONES);
    send_request(FUNC_POP, '0);
  endtask

  // Fills the ring to SLOTS-1 and keeps pushing so the oldest records drop.
  task automatic test_overwrite_when_full();
    repeat (RING_SLOTS + 1) send_request(FUNC_PUSH, random_record());
  endtask

  // The sender holds off until every outstanding result has come back.
  task automatic test_drain_pause();
    wait_until_drained();
    repeat (8) send_request(FUNC_PUSH, random_record());
    wait_until_drained();
    repeat (RING_SLOTS) send_request(FUNC_POP, random_record());
    wait_until_drained();
  endtask

  // Segments alternate between push-heavy, pop-heavy and balanced mixes so
  // the ring swings between full and empty often.
  task automatic test_random_mix(input int unsigned segments, input int unsigned per_segment);
    int unsigned push_weight;
    for (int unsigned s = 0; s < segments; s++) begin
      push_weight      = (s % 3 == 0) ? 6 : (s % 3 == 1) ? 2 : 4;
      request_gaps_on  = ($urandom_range(0, 3) != 0);
      result_stalls_on = ($urandom_range(0, 3) != 0);
      for (int unsigned i = 0; i < per_segment; i++) begin
        if ($urandom_range(0, 7) < push_weight) send_request(FUNC_PUSH, random_record());
        else send_request(FUNC_POP, random_record());
      end
    end
  endtask

  task automatic test_back_to_back();
    request_gaps_on  = 1'b0;
    result_stalls_on = 1'b0;
    test_random_mix(1, 100);
    request_gaps_on  = 1'b0;
    result_stalls_on = 1'b0;
    for (int unsigned i = 0; i < 100; i++)
      send_request(($urandom_range(0, 1) == 0) ? FUNC_PUSH : FUNC_POP, random_record());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_pop();
    test_extreme_records();
    test_overwrite_when_full();
    test_drain_pause();
    test_random_mix(10, 100);
    test_back_to_back();
    wait_until_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests and %0d results: %0d pops (%0d on an empty ring), %0d drops.",
             n_requests, n_results, n_pops, n_empty_pops, n_drops);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
